// File: sv/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Types, widths and codes shared by the serial line editor modules.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int LINE_DEPTH  = 32;
  localparam int CNT_W       = $clog2(LINE_DEPTH);
  localparam int CHAR_W      = 8;
  localparam int IDX_W       = 5;
  localparam int COUNT_OUT_W = 5;
  localparam int FUNC_W      = 2;
  localparam int CFG_IDX_W   = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CHAR_W-1:0] BKSP_RESET = CHAR_W'(8);
  localparam logic [CHAR_W-1:0] TERM_RESET = CHAR_W'(13);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RX    = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BKSP = 2'd0,
    CFG_TERM = 2'd1,
    CFG_ECHO = 2'd2,
    CFG_NONE = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CHAR,
    OP_BKSP,
    OP_TERM,
    OP_READ,
    OP_CLEAR
  } op_kind_t;

  // Classified word passed from the front end to the back end
  typedef struct packed {
    op_kind_t          kind;
    logic              echo_en;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  index;
  } op_t;

endpackage

// File: sv/sle_if.sv
// ----------------------------------------------------------------------------
// sle_if
// Valid/ready channels of the serial line editor: command in, result out.
// ----------------------------------------------------------------------------
interface sle_cmd_if import sle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CHAR_W-1:0] rx_char;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, func, rx_char, read_index, input ready);
  modport sink   (input valid, func, rx_char, read_index, output ready);
endinterface

interface sle_res_if import sle_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   echo_valid;
  logic [CHAR_W-1:0]      echo_char;
  logic [COUNT_OUT_W-1:0] char_count;
  logic                   line_done;
  logic                   overflow;
  logic [CHAR_W-1:0]      read_char;

  modport source (output valid, echo_valid, echo_char, char_count, line_done, overflow,
                  read_char, input ready);
  modport sink   (input valid, echo_valid, echo_char, char_count, line_done, overflow,
                  read_char, output ready);
endinterface

// File: sv/sle_front.sv
// ----------------------------------------------------------------------------
// sle_front
// Holds the configuration registers and classifies each command word.
// ----------------------------------------------------------------------------
module sle_front import sle_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CHAR_W-1:0]    cfg_data,
  input  logic                 cmd_valid,
  input  logic [FUNC_W-1:0]    cmd_func,
  input  logic [CHAR_W-1:0]    cmd_char,
  input  logic [IDX_W-1:0]     cmd_index,
  output logic                 push,
  output op_t                  push_op
);

  logic [CHAR_W-1:0] backspace_code;
  logic [CHAR_W-1:0] terminator_code;
  logic              echo_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      backspace_code  <= BKSP_RESET;
      terminator_code <= TERM_RESET;
      echo_enable     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BKSP: backspace_code  <= cfg_data;
        CFG_TERM: terminator_code <= cfg_data;
        CFG_ECHO: echo_enable     <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    push_op.echo_en = echo_enable;
    push_op.ch      = cmd_char;
    push_op.index   = cmd_index;
    case (func_t'(cmd_func))
      FUNC_RX: begin
        // backspace wins when both codes match
        if (cmd_char == backspace_code) begin
          push_op.kind = OP_BKSP;
        end else if (cmd_char == terminator_code) begin
          push_op.kind = OP_TERM;
        end else begin
          push_op.kind = OP_CHAR;
        end
      end
      FUNC_READ:  push_op.kind = OP_READ;
      FUNC_CLEAR: push_op.kind = OP_CLEAR;
      default:    push_op.kind = OP_NOP;
    endcase
  end

  assign push = cmd_valid;

endmodule

// File: sv/sle_queue.sv
// ----------------------------------------------------------------------------
// sle_queue
// Short FIFO of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module sle_queue import sle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  logic do_push;
  logic do_pop;

  assign full       = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_op    = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

// File: sv/sle_back.sv
// ----------------------------------------------------------------------------
// sle_back
// Carries out queued words on the line store and registers each result.
// ----------------------------------------------------------------------------
module sle_back import sle_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  op_t               head_op,
  output logic              pop,
  sle_res_if.source         res
);

  logic [CHAR_W-1:0] line_store [LINE_DEPTH];
  logic [CNT_W-1:0]  fill_count;
  logic              terminator_seen;
  logic              overflow_flag;

  logic [CNT_W-1:0]  fill_count_next;
  logic              terminator_seen_next;
  logic              overflow_flag_next;

  logic              wr_en;
  logic [CNT_W-1:0]  wr_idx;
  logic [CHAR_W-1:0] wr_data;
  logic              clear_all;
  logic              echo_v;
  logic [CHAR_W-1:0] echo_c;
  logic [CHAR_W-1:0] rd;

  logic                line_full;
  logic [CNT_W+IDX_W-1:0] ridx_wide;
  logic                ridx_ok;
  logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

  assign pop       = head_valid && (!res.valid || res.ready);
  assign line_full = fill_count == CNT_W'(LINE_DEPTH - 1);
  assign ridx_wide = {{CNT_W{1'b0}}, head_op.index};
  assign ridx_ok   = ridx_wide < (CNT_W+IDX_W)'(LINE_DEPTH);

  always_comb begin
    fill_count_next      = fill_count;
    terminator_seen_next = terminator_seen;
    overflow_flag_next   = overflow_flag;
    wr_en     = 1'b0;
    wr_idx    = fill_count;
    wr_data   = '0;
    clear_all = 1'b0;
    echo_v    = 1'b0;
    rd        = '0;
    case (head_op.kind)
      OP_CHAR, OP_BKSP, OP_TERM: begin
        if (line_full) begin
          // drop the character
          overflow_flag_next = 1'b1;
        end else begin
          overflow_flag_next = 1'b0;
          if (head_op.kind == OP_BKSP) begin
            if (fill_count != '0) begin
              echo_v          = 1'b1;
              fill_count_next = fill_count - 1'b1;
              wr_en           = 1'b1;
              wr_idx          = fill_count - 1'b1;
            end
          end else if (head_op.kind == OP_TERM) begin
            echo_v               = 1'b1;
            terminator_seen_next = 1'b1;
            wr_en                = 1'b1;
          end else begin
            echo_v               = 1'b1;
            terminator_seen_next = 1'b0;
            wr_en                = 1'b1;
            wr_data              = head_op.ch;
            fill_count_next      = fill_count + 1'b1;
          end
        end
      end
      OP_READ: begin
        if (ridx_ok) begin
          rd = line_store[ridx_wide[CNT_W-1:0]];
        end
      end
      OP_CLEAR: begin
        clear_all            = 1'b1;
        fill_count_next      = '0;
        terminator_seen_next = 1'b0;
        overflow_flag_next   = 1'b0;
      end
      default: ;
    endcase
    echo_v = echo_v && head_op.echo_en;
    echo_c = echo_v ? head_op.ch : '0;
  end

  assign count_wide = {{COUNT_OUT_W{1'b0}}, fill_count_next};

  always_ff @(posedge clk) begin
    if (rst || (pop && clear_all)) begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
        line_store[i] <= '0;
      end
    end else if (pop && wr_en) begin
      line_store[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count      <= '0;
      terminator_seen <= 1'b0;
      overflow_flag   <= 1'b0;
      res.valid       <= 1'b0;
    end else begin
      if (pop) begin
        fill_count      <= fill_count_next;
        terminator_seen <= terminator_seen_next;
        overflow_flag   <= overflow_flag_next;
        res.valid       <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // result payload: load on every pop, hold otherwise
  always_ff @(posedge clk) begin
    if (pop) begin
      res.echo_valid <= echo_v;
      res.echo_char  <= echo_c;
      res.char_count <= count_wide[COUNT_OUT_W-1:0];
      res.line_done  <= terminator_seen_next;
      res.overflow   <= overflow_flag_next;
      res.read_char  <= rd;
    end
  end

endmodule

// File: sv/serial_line_editor.sv
// ----------------------------------------------------------------------------
// serial_line_editor
// Builds a command line from received characters, with backspace and echo.
// ----------------------------------------------------------------------------
//   channel  dir  handshake        payload
//   cmd      in   valid / ready    func, rx_char, read_index
//   res      out  valid / ready    echo_valid, echo_char, char_count,
//                                  line_done, overflow, read_char
//   cfg      in   cfg_we           cfg_index, cfg_data
//
// One word per cycle sustained while res.ready stays high; a taken command lands in
// the queue, then loads the back-end result register that drives res.valid.
// The two-entry queue decouples command intake from result stalls; cmd.ready
// drops only when the queue is full.
// Synchronous reset clears the line store (flip-flops), count, flags and
// restores backspace 8, terminator 13, echo on.
// ----------------------------------------------------------------------------
module serial_line_editor import sle_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  sle_cmd_if.sink              cmd,
  sle_res_if.source            res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CHAR_W-1:0]    cfg_data
);

  logic push;
  op_t  push_op;
  logic full;
  logic pop;
  logic head_valid;
  op_t  head_op;

  assign cmd.ready = !full;

  sle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd.valid),
    .cmd_func  (cmd.func),
    .cmd_char  (cmd.rx_char),
    .cmd_index (cmd.read_index),
    .push      (push),
    .push_op   (push_op)
  );

  sle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  sle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .res        (res)
  );

endmodule
